// ----- src/mafs_pkg.sv -----
`default_nettype none

package mafs_pkg;

  // field widths
  localparam int unsigned NumFeaturesDefault = 1024;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned ValW   = 32;
  localparam int unsigned OutW   = 18;
  localparam int unsigned QuotW  = 16;

  // packed stream widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  // action codes carried in tuser
  localparam logic ActAccum = 1'b0;
  localparam logic ActScale = 1'b1;

  // request to the shared divide / compare unit
  typedef struct packed {
    logic            start;
    logic            cmp_only;
    logic [ValW-1:0] dividend;
    logic [ValW-1:0] divisor;
  } div_req_t;

  // answer of the shared unit, valid for one cycle when done is high
  typedef struct packed {
    logic             done;
    logic             sat;
    logic [QuotW-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

// ----- src/max_abs_feature_scaler_top.sv -----
`default_nettype none

// channel   dir  tdata (low bit up)                          tlast        tuser
// s_axis    in   feature_index[9:0], sample_value[41:10]     row_end      action
// m_axis    out  scaled_value[17:0]                          row_end_out  -
//
// an accumulate transaction does a table read, one compare in the shared
// divide unit and a table write; a scale transaction stops after the
// compare if the maximum is zero or not above the magnitude, otherwise
// it runs 16 restoring steps; after reset the table is zeroed one entry a
// cycle, all NUM_FEATURES entries, while s_axis_tready stays low
// a held result does not block the next input; a second result waits until
// m_axis_tready takes the first
module max_abs_feature_scaler_top import mafs_pkg::*; #(
  parameter int unsigned NUM_FEATURES = NumFeaturesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // feature_index, sample_value
  input  wire logic                s_axis_tlast,
  input  wire logic                s_axis_tuser,  // action
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [OutDataW-1:0] m_axis_tdata,  // scaled_value
  output logic                     m_axis_tlast
);

  localparam int unsigned AddrW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic            act_q;
  logic [IdxW-1:0] idx_q;
  logic            idx_ok_q;
  logic [ValW-1:0] mag_q;
  logic            neg_q;
  logic            rend_q;
  logic            zero_q;
  logic [QuotW:0]  q_q;
  logic            out_valid_q;
  logic [OutW-1:0] out_data_q;
  logic            out_last_q;

  logic            mem_ready;
  logic [ValW-1:0] rd_data;
  logic            rd_en;
  logic [AddrW-1:0] addr;
  logic            wr_en;
  div_req_t        div_req;
  div_res_t        div_res;

  logic [ValW-1:0] in_raw;
  logic [IdxW-1:0] in_idx;
  logic            accept;
  logic            out_free;
  logic [OutW-1:0] signed_q;

  // input unpack and handshake
  always_comb begin
    in_idx        = s_axis_tdata[IdxW-1:0];
    in_raw        = s_axis_tdata[IdxW+ValW-1:IdxW];
    s_axis_tready = (state_q == ST_IDLE);
    accept        = s_axis_tvalid & s_axis_tready;
    out_free      = ~out_valid_q | m_axis_tready;
  end

  // table access and shared unit request
  always_comb begin
    addr             = idx_ok_q ? AddrW'(idx_q) : '0;
    rd_en            = (state_q == ST_READ);
    wr_en            = (state_q == ST_WAIT) && div_res.done && (act_q == ActAccum) &&
                       div_res.sat && idx_ok_q;
    div_req.start    = (state_q == ST_START);
    div_req.cmp_only = (act_q == ActAccum) || !idx_ok_q || (rd_data == '0);
    div_req.dividend = mag_q;
    div_req.divisor  = rd_data;
  end

  // sign applied to the quotient
  always_comb begin
    signed_q = neg_q ? (OutW'(0) - OutW'(q_q)) : OutW'(q_q);
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          if (mem_ready) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_START;
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_res.done) begin
            state_q <= (act_q == ActScale) ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // item and result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= s_axis_tuser;
      idx_q    <= in_idx;
      idx_ok_q <= (32'(in_idx) < NUM_FEATURES);
      neg_q    <= in_raw[ValW-1];
      mag_q    <= in_raw[ValW-1] ? (~in_raw + 1'b1) : in_raw;
      rend_q   <= s_axis_tlast;
    end
    if (state_q == ST_START) begin
      zero_q <= !idx_ok_q || (rd_data == '0);
    end
    if (state_q == ST_WAIT && div_res.done) begin
      if (zero_q) begin
        q_q <= '0;
      end else if (div_res.sat) begin
        q_q <= {1'b1, {QuotW{1'b0}}};
      end else begin
        q_q <= {1'b0, div_res.quot};
      end
    end
    if (state_q == ST_EMIT && out_free) begin
      out_data_q <= signed_q;
      out_last_q <= rend_q;
    end
  end

  mafs_max_mem #(
    .NUM_FEATURES(NUM_FEATURES)
  ) u_max_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(addr),
    .wr_data_i(mag_q),
    .ready_o  (mem_ready)
  );

  mafs_divider u_divider (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .res_o (div_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutW){1'b0}}, out_data_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- src/mafs_divider.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle; first cycle is a plain
// magnitude compare which also serves the maximum update
module mafs_divider import mafs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_res_t      res_o
);

  localparam int unsigned CntW = (QuotW > 1) ? $clog2(QuotW) : 1;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CMP,
    DV_STEP
  } dv_state_e;

  dv_state_e       state_q;
  logic [ValW:0]   rem_q;
  logic [ValW-1:0] div_q;
  logic            cmp_only_q;
  logic [CntW-1:0] cnt_q;
  logic [QuotW-1:0] quot_q;
  logic            done_q;
  logic            sat_q;

  logic [ValW:0] div_ext;
  logic          ge_now;
  logic [ValW:0] shifted;
  logic [ValW:0] diff;
  logic          step_ge;

  // shared compare / subtract datapath
  always_comb begin
    div_ext = {1'b0, div_q};
    ge_now  = (rem_q >= div_ext);
    shifted = {rem_q[ValW-1:0], 1'b0};
    step_ge = (shifted >= div_ext);
    diff    = shifted - div_ext;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      sat_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        DV_IDLE: begin
          if (req_i.start) begin
            state_q <= DV_CMP;
          end
        end
        DV_CMP: begin
          sat_q <= ge_now;
          cnt_q <= '0;
          if (ge_now || cmp_only_q) begin
            done_q  <= 1'b1;
            state_q <= DV_IDLE;
          end else begin
            state_q <= DV_STEP;
          end
        end
        DV_STEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(QuotW - 1)) begin
            done_q  <= 1'b1;
            state_q <= DV_IDLE;
          end
        end
        default: begin
          state_q <= DV_IDLE;
        end
      endcase
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && req_i.start) begin
      rem_q      <= {1'b0, req_i.dividend};
      div_q      <= req_i.divisor;
      cmp_only_q <= req_i.cmp_only;
      quot_q     <= '0;
    end else if (state_q == DV_STEP) begin
      rem_q  <= step_ge ? diff : shifted;
      quot_q <= {quot_q[QuotW-2:0], step_ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.quot = quot_q;

endmodule

`default_nettype wire

// ----- src/mafs_max_mem.sv -----
`default_nettype none

// per-feature maximum store with a zeroing sweep after reset
module mafs_max_mem import mafs_pkg::*; #(
  parameter int unsigned NUM_FEATURES = NumFeaturesDefault,
  localparam int unsigned AddrW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [ValW-1:0]  rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [ValW-1:0]  wr_data_i,
  output logic                  ready_o
);

  logic [ValW-1:0]  mem_q [NUM_FEATURES];
  logic             clearing_q;
  logic [AddrW-1:0] clr_addr_q;

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [ValW-1:0]  wdata;

  // sweep owns the write port until it finishes
  always_comb begin
    we    = clearing_q | wr_en_i;
    waddr = clearing_q ? clr_addr_q : wr_addr_i;
    wdata = clearing_q ? '0 : wr_data_i;
  end

  // clearing sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AddrW'(NUM_FEATURES - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // storage array, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

  assign ready_o = ~clearing_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  import mafs_pkg::*;

  // one awaited output transaction
  typedef struct {
    logic [OutW-1:0] scaled;
    logic            row_end;
  } scaled_entry_t;

  // keeps its own copy of the per-feature maximum table and the results in flight
  class scaler_scoreboard;
    logic [ValW-1:0] feature_max [NumFeaturesDefault];
    scaled_entry_t   pending_quotients[$];
    int unsigned     errors;

    function new();
      foreach (feature_max[i]) feature_max[i] = '0;
      errors = 0;
    endfunction

    // signed q1.16 quotient of a raw q16.16 value over a stored maximum
    function logic [OutW-1:0] scaled_quotient(logic [ValW-1:0] raw, logic [ValW-1:0] mx);
      logic [ValW-1:0] mag;
      logic [47:0]     num;
      logic [47:0]     q48;
      logic [OutW-1:0] q;
      mag = raw[ValW-1] ? (~raw + 1'b1) : raw;
      if (mx == '0) begin
        q = '0;
      end else if (mag >= mx) begin
        q = OutW'(32'h0001_0000);
      end else begin
        num = {mag, 16'h0000};
        q48 = num / {16'h0000, mx};
        q = q48[OutW-1:0];
      end
      return raw[ValW-1] ? (~q + 1'b1) : q;
    endfunction

    // accepted input transaction: update the maximum or queue a quotient
    function void note_input(logic act, logic [IdxW-1:0] idx, logic [ValW-1:0] raw,
                             logic rend);
      scaled_entry_t e;
      logic [ValW-1:0] mag;
      mag = raw[ValW-1] ? (~raw + 1'b1) : raw;
      if (act == ActAccum) begin
        if (mag > feature_max[idx]) feature_max[idx] = mag;
      end else begin
        e.scaled = scaled_quotient(raw, feature_max[idx]);
        e.row_end = rend;
        pending_quotients.push_back(e);
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // accepted output transaction against the oldest awaited quotient
    task check_result(logic [OutW-1:0] scaled, logic rend);
      scaled_entry_t e;
      if (pending_quotients.size() == 0) begin
        report($sformatf("unexpected result scaled=%h row_end=%b", scaled, rend));
      end else begin
        e = pending_quotients.pop_front();
        if (scaled !== e.scaled)
          report($sformatf("scaled_value got %h want %h", scaled, e.scaled));
        if (rend !== e.row_end)
          report($sformatf("row_end_out got %b want %b", rend, e.row_end));
      end
    endtask

    function int unsigned outstanding();
      return pending_quotients.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // feature_index, sample_value
  logic                s_axis_tlast;
  logic                s_axis_tuser;   // action
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // scaled_value
  logic                m_axis_tlast;

  scaler_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned rx_hold_len;
  int unsigned items_sent;

  max_abs_feature_scaler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk_i) begin
    if (rx_hold_len != 0) begin
      m_axis_tready = 1'b0;
      rx_hold_len--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[OutW-1:0], m_axis_tlast);
  end

  // drive one input transaction; entered and left at a falling edge
  task automatic send_entry(input logic act, input logic [IdxW-1:0] idx,
                            input logic [ValW-1:0] raw, input logic rend);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tlast  = rend;
    s_axis_tdata  = {{(InDataW-IdxW-ValW){1'b0}}, raw, idx};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    sb.note_input(act, idx, raw, rend);
    items_sent++;
    @(negedge clk_i);
  endtask

  // stop offering and wait for every queued quotient to come out
  task automatic drain_outputs();
    s_axis_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  // random magnitude over all scales, random sign
  function automatic logic [ValW-1:0] random_sample();
    logic [ValW-1:0] v;
    v = $urandom() >> $urandom_range(31);
    if ($urandom_range(1)) v = ~v + 1'b1;
    return v;
  endfunction

  // value for a scale transaction, mostly within the feature maximum
  function automatic logic [ValW-1:0] sample_under(logic [ValW-1:0] mx);
    logic [ValW-1:0] m;
    case ($urandom_range(9))
      0:       m = mx;
      1:       m = mx + $urandom_range(1, 1000);
      2:       m = $urandom();
      default: m = (mx == '0) ? $urandom() >> $urandom_range(31) : $urandom_range(mx, 0);
    endcase
    if ($urandom_range(1)) m = ~m + 1'b1;
    return m;
  endfunction

  // rows of accumulate passes followed by scale passes, with some noise
  task automatic random_rows(input int unsigned target);
    logic [IdxW-1:0] feats[6];
    int unsigned nf;
    int unsigned nscale;
    while (items_sent < target) begin
      if ($urandom_range(99) < 10) begin
        send_entry(1'($urandom_range(1)), IdxW'($urandom_range(1023)), $urandom(),
                   1'($urandom_range(1)));
      end else begin
        nf = $urandom_range(1, 6);
        for (int i = 0; i < nf; i++)
          feats[i] = $urandom_range(1) ? IdxW'($urandom_range(15)) :
                                         IdxW'($urandom_range(1023));
        if ($urandom_range(99) >= 20) begin
          for (int i = 0; i < nf; i++)
            repeat ($urandom_range(1, 3))
              send_entry(ActAccum, feats[i], random_sample(), 1'($urandom_range(1)));
        end
        for (int i = 0; i < nf; i++) begin
          nscale = $urandom_range(1, 3);
          for (int k = 0; k < nscale; k++)
            send_entry(ActScale, feats[i], sample_under(sb.feature_max[feats[i]]),
                       (i == nf - 1) && (k == nscale - 1));
        end
      end
    end
  endtask

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    s_axis_tuser   = ActAccum;
    m_axis_tready  = 1'b0;
    rst_ni         = 1'b0;
    rx_hold_len    = 0;
    items_sent     = 0;
    send_idle_pct  = 19;
    recv_stall_pct = 52;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty maximum, extremes, saturation, exact unity
    send_entry(ActScale, 10'd0,    32'h7FFF_FFFF, 1'b0);
    send_entry(ActAccum, 10'd0,    32'h7FFF_FFFF, 1'b1);
    send_entry(ActScale, 10'd0,    32'h7FFF_FFFF, 1'b0);
    send_entry(ActScale, 10'd0,    32'h8000_0000, 1'b1);
    send_entry(ActScale, 10'd0,    32'h0000_0000, 1'b0);
    send_entry(ActScale, 10'd0,    32'hFFFF_FFFF, 1'b0);
    send_entry(ActAccum, 10'd1023, 32'h8000_0000, 1'b0);
    send_entry(ActScale, 10'd1023, 32'h4000_0000, 1'b1);
    send_entry(ActScale, 10'd1023, 32'hC000_0000, 1'b0);
    send_entry(ActAccum, 10'd1023, 32'h0000_0001, 1'b0);
    send_entry(ActScale, 10'd1023, 32'h7FFF_FFFF, 1'b0);
    send_entry(ActAccum, 10'd5,    32'h0001_0000, 1'b0);
    send_entry(ActScale, 10'd5,    32'h0001_8000, 1'b0);
    send_entry(ActScale, 10'd5,    32'hFFFF_0000, 1'b1);
    send_entry(ActScale, 10'd5,    32'h0000_8000, 1'b0);
    send_entry(ActScale, 10'd5,    32'h0000_0001, 1'b0);
    send_entry(ActAccum, 10'd5,    32'hFFF0_0000, 1'b1);
    send_entry(ActScale, 10'd5,    32'hFFF0_0001, 1'b0);
    send_entry(ActScale, 10'd5,    32'h000A_BCDE, 1'b0);
    send_entry(ActAccum, 10'd512,  32'h0000_0000, 1'b0);
    send_entry(ActScale, 10'd512,  32'h0000_0005, 1'b1);
    send_entry(ActScale, 10'd1,    32'h8000_0000, 1'b1);

    // long receiver hold-off while scale transactions keep coming
    rx_hold_len = 400;
    repeat (24) send_entry(ActScale, 10'd5, sample_under(sb.feature_max[5]),
                           1'($urandom_range(1)));
    drain_outputs();

    random_rows(380);

    // sender mostly idle, receiver mostly ready
    send_idle_pct  = 52;
    recv_stall_pct = 19;
    random_rows(740);
    drain_outputs();

    // full rate both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_rows(1100);

    drain_outputs();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
